@@ hw/rtl/lbpc_pkg.sv @@
// Shared types, action and mode codes and blink timing constants for the LED blink controller.
package lbpc_pkg;

	localparam int NUM_LEDS = 2;
	localparam int MASK_W   = 2;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_SET    = 3'd1,
		ACT_ON     = 3'd2,
		ACT_OFF    = 3'd3,
		ACT_TOGGLE = 3'd4
	} action_t;

	localparam logic [2:0] MODE_OFF  = 3'd0;
	localparam logic [2:0] MODE_ON   = 3'd1;
	localparam logic [2:0] MODE_SLOW = 3'd2;
	localparam logic [2:0] MODE_FAST = 3'd3;
	localparam logic [2:0] MODE_BLIP = 3'd4;

	localparam logic [10:0] PERIOD_SLOW = 11'd1000;
	localparam logic [10:0] PERIOD_FAST = 11'd100;
	localparam logic [9:0]  ON_SLOW     = 10'd500;
	localparam logic [9:0]  ON_FAST     = 10'd50;
	localparam logic [9:0]  ON_BLIP     = 10'd100;

	typedef struct packed {
		logic [2:0] action;
		logic       sel;
		logic [2:0] mode;
	} lbpc_item_t;

endpackage

@@ hw/rtl/led_blink_pattern_controller.sv @@
// Top level: input register, LED cells and result register with request handshakes.
// A request is held in the input register, then loaded into the result register and
// offered from there; throughput is one request per cycle, held back only while the
// result register is full and stalled.
// Reset (asynchronous, active low): every LED in forced-off mode, counters zero, all dark,
// no request or result held. No clearing pass is needed.
module led_blink_pattern_controller (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] action,
	input  logic [1:0] led_mask,
	input  logic [2:0] mode,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] lit_mask
);

	// input register
	logic       valid_s1;
	logic [2:0] action_s1;
	logic [1:0] mask_s1;
	logic [2:0] mode_s1;

	// result register
	logic       out_valid_q;
	logic [1:0] lit_mask_q;

	logic                      adv;
	logic [lbpc_pkg::NUM_LEDS-1:0] lit_next;
	logic [1:0]                lit_new;

	// The held request moves on whenever the result register is free or being drained.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset; capture only on acceptance.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			mask_s1   <= led_mask;
			mode_s1   <= mode;
		end
	end

	// One cell per LED; mask bits with no LED behind them are dropped, and
	// LEDs beyond the mask width are never selected.
	for (genvar k = 0; k < lbpc_pkg::NUM_LEDS; k++) begin : g_led
		lbpc_pkg::lbpc_item_t item;
		always_comb begin
			item.action = action_s1;
			item.mode   = mode_s1;
			if (k < lbpc_pkg::MASK_W) item.sel = mask_s1[k % lbpc_pkg::MASK_W];
			else                      item.sel = 1'b0;
		end
		lbpc_led_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (valid_s1 && adv),
			.item     (item),
			.lit_next (lit_next[k])
		);
	end

	// Report only the low two LEDs; pad with dark when fewer exist.
	always_comb begin
		lit_new = 2'b00;
		for (int k = 0; k < 2; k++) begin
			if (k < lbpc_pkg::NUM_LEDS) lit_new[k] = lit_next[k % lbpc_pkg::NUM_LEDS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			lit_mask_q <= lit_new;
		end
	end

	assign out_valid = out_valid_q;
	assign lit_mask  = lit_mask_q;

`ifndef NO_ASSERTIONS
	a_stall_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with nothing held");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv) |=> out_valid_q)
		else $error("advanced request produced no result");
	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !valid_s1) |=> !out_valid_q)
		else $error("result repeated after being taken");
`endif

endmodule

@@ hw/rtl/lbpc_led_cell.sv @@
// One LED: mode, millisecond counter and lit bit, with their next-state logic.
module lbpc_led_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  lbpc_pkg::lbpc_item_t item,
	output logic               lit_next
);

	logic [2:0]  mode_q, mode_d;
	logic [9:0]  count_q, count_d;
	logic        lit_q, lit_d;
	logic [10:0] sum;
	logic [10:0] period;
	logic [9:0]  on_len;
	logic [9:0]  wrapped;

	always_comb begin
		sum = {1'b0, count_q} + 11'd1;
		case (mode_q)
			lbpc_pkg::MODE_FAST: begin
				period = lbpc_pkg::PERIOD_FAST;
				on_len = lbpc_pkg::ON_FAST;
			end
			lbpc_pkg::MODE_BLIP: begin
				period = lbpc_pkg::PERIOD_SLOW;
				on_len = lbpc_pkg::ON_BLIP;
			end
			default: begin
				period = lbpc_pkg::PERIOD_SLOW;
				on_len = lbpc_pkg::ON_SLOW;
			end
		endcase
		// increment first, then wrap at the period
		wrapped = (sum >= period) ? 10'd0 : sum[9:0];
	end

	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		lit_d   = lit_q;
		unique case (lbpc_pkg::action_t'(item.action))
			lbpc_pkg::ACT_TICK: begin
				case (mode_q) inside
					lbpc_pkg::MODE_OFF: lit_d = 1'b0;
					lbpc_pkg::MODE_ON:  lit_d = 1'b1;
					lbpc_pkg::MODE_SLOW, lbpc_pkg::MODE_FAST, lbpc_pkg::MODE_BLIP: begin
						count_d = wrapped;
						lit_d   = (wrapped < on_len);
					end
					default: ;
				endcase
			end
			lbpc_pkg::ACT_SET: begin
				if (item.sel && (mode_q != item.mode)) begin
					mode_d  = item.mode;
					count_d = 10'd0;
				end
			end
			lbpc_pkg::ACT_ON: begin
				if (item.sel) lit_d = 1'b1;
			end
			lbpc_pkg::ACT_OFF: begin
				if (item.sel) lit_d = 1'b0;
			end
			lbpc_pkg::ACT_TOGGLE: begin
				if (item.sel) lit_d = ~lit_q;
			end
			default: ;
		endcase
	end

	assign lit_next = lit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lbpc_pkg::MODE_OFF;
			count_q <= 10'd0;
			lit_q   <= 1'b0;
		end else if (en) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			lit_q   <= lit_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < lbpc_pkg::PERIOD_SLOW[9:0])
		else $error("blink counter beyond slow period");
	a_fast_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == lbpc_pkg::MODE_FAST) |-> (count_q < lbpc_pkg::PERIOD_FAST[9:0]))
		else $error("fast blink counter beyond its period");
	a_turn_on: assert property (@(posedge clk) disable iff (!arst_n)
		(en && item.sel && (item.action == lbpc_pkg::ACT_ON)) |=> lit_q)
		else $error("turn on request did not light the LED");
`endif

endmodule
